/* rtl/drpi_pkg.sv */
package drpi_pkg;

    // Field widths.
    localparam int VEL_W  = 24;
    localparam int DT_W   = 24;
    localparam int POS_W  = 32;
    localparam int ANG_W  = 32;
    localparam int Q15_W  = 16;

    // CORDIC values are Q2.30 carried with headroom.
    localparam int CV_W   = 33;
    localparam int CNT_W  = 5;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [CV_W-1:0] CORDIC_X0 = 33'sd652032874;

    // Shared multiplier: signed 33 x 33.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Reciprocal of 2pi in Q0.32, used to turn radians into a binary angle.
    localparam int K_W = 30;
    localparam logic [K_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;

    // Item kinds carried in tuser.
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORD_A,
        ST_MUL_D,
        ST_DIST,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_PL,
        ST_MUL_PH,
        ST_HEAD,
        ST_INIT_B,
        ST_CORD_B,
        ST_CAP_B,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MUL_SPEED_DT,
        MUL_RATE_DT,
        MUL_DIST_COS,
        MUL_DIST_SIN,
        MUL_PLO_K,
        MUL_PHI_K
    } t_mul_sel;

    // What the datapath does in this cycle, mostly with the product registered in the previous cycle.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DIST,
        ACT_P,
        ACT_X,
        ACT_Y,
        ACT_ACC,
        ACT_HEAD,
        ACT_OUT
    } t_act;

    typedef struct packed {
        logic     load_vel;
        logic     load_tick;
        logic     cordic_init_half;
        logic     cordic_step;
        logic     cap_cs;
        t_mul_sel mul_sel;
        t_act     act;
    } t_dp_cmd;

    typedef struct packed {
        logic cordic_last;
    } t_dp_status;

    // Arctangent of 2^-i as a binary angle, rounded.
    function automatic logic [ANG_W-1:0] atan_bam(input logic [CNT_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/dead_reckoning_pose_integrator_top.sv */
// Planar dead-reckoning pose integrator.
// Input stream: tuser is the item kind (0 velocity command, 1 tick). tdata carries
// the forward speed, the yaw rate and the elapsed time. A command stores both
// velocities and gives no result. A tick advances x and y along the heading held
// before the tick, then advances the heading by yaw rate times time.
// Output stream: one result per tick with position, heading, the yaw quaternion
// and the stored velocities.
// Timing: a tick runs two CORDIC passes of CORDIC_STEPS (capped at 24) steps and
// six products on one shared 33 x 33 multiplier. No item is taken while a tick is
// in work; the next item is taken once its result has entered the output register.
// A command leaves the block idle, ready for the next item.
// Stalls: the result sits in an output register. Commands and a new tick are taken
// while it waits; a finished tick holds in its last state until the register is free.
// Reset: position, heading and stored velocities clear to zero, and no result is
// pending.
module dead_reckoning_pose_integrator_top
    import drpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [23:0] linear_velocity, [47:24] angular_velocity, [71:48] elapsed_time
    input  logic [71:0]  i_s_axis_tdata,
    // [0] kind
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] heading_angle, [111:96] quat_z,
    // [127:112] quat_w, [151:128] speed_echo, [175:152] turn_rate_echo
    output logic [175:0] o_m_axis_tdata
);

    t_dp_cmd                 cmd;
    t_dp_status              status;
    logic signed [POS_W-1:0] pos_x, pos_y;
    logic [ANG_W-1:0]        heading_angle;
    logic signed [Q15_W-1:0] quat_z, quat_w;
    logic signed [VEL_W-1:0] speed_echo, turn_rate_echo;

    // Sequencer.
    drpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_kind   (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and state.
    drpi_datapath #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_linear_velocity  ($signed(i_s_axis_tdata[23:0])),
        .i_angular_velocity ($signed(i_s_axis_tdata[47:24])),
        .i_elapsed_time     (i_s_axis_tdata[71:48]),
        .o_pos_x            (pos_x),
        .o_pos_y            (pos_y),
        .o_heading_angle    (heading_angle),
        .o_quat_z           (quat_z),
        .o_quat_w           (quat_w),
        .o_speed_echo       (speed_echo),
        .o_turn_rate_echo   (turn_rate_echo)
    );

    // Pack the result.
    assign o_m_axis_tdata = {turn_rate_echo, speed_echo, quat_w, quat_z,
                             heading_angle, pos_y, pos_x};

endmodule

/* rtl/drpi_cordic.sv */
module drpi_cordic
    import drpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_init,
    input  logic [ANG_W-1:0]       i_angle,
    input  logic                   i_step,
    output logic                   o_last,
    output logic signed [CV_W-1:0] o_cos,
    output logic signed [CV_W-1:0] o_sin
);

    localparam int N_EFF = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(N_EFF - 1);

    logic signed [CV_W-1:0] r_x, r_y, r_z;
    logic signed [CV_W-1:0] n_x, n_y, n_z;
    logic                   r_flip;
    logic [CNT_W-1:0]       r_cnt;
    logic                   fold;
    logic [ANG_W-1:0]       folded;
    logic signed [CV_W-1:0] xs, ys, at;

    // Fold the angle by pi into the right half plane; the results are negated back.
    assign fold   = i_angle[ANG_W-1] ^ i_angle[ANG_W-2];
    assign folded = {i_angle[ANG_W-1] ^ fold, i_angle[ANG_W-2:0]};

    // One micro-rotation toward zero residual angle.
    always_comb begin
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        at = {1'b0, atan_bam(r_cnt)};
        if (!r_z[CV_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_init) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Rotation registers.
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_x    <= CORDIC_X0;
            r_y    <= '0;
            r_z    <= {folded[ANG_W-1], folded};
            r_flip <= fold;
        end else if (i_step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_last = (r_cnt == LAST_CNT);
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

/* rtl/drpi_datapath.sv */
module drpi_datapath
    import drpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic signed [VEL_W-1:0] i_linear_velocity,
    input  logic signed [VEL_W-1:0] i_angular_velocity,
    input  logic [DT_W-1:0]         i_elapsed_time,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic [ANG_W-1:0]        o_heading_angle,
    output logic signed [Q15_W-1:0] o_quat_z,
    output logic signed [Q15_W-1:0] o_quat_w,
    output logic signed [VEL_W-1:0] o_speed_echo,
    output logic signed [VEL_W-1:0] o_turn_rate_echo
);

    localparam int SUM_W = POS_W + 5;
    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sh80000000);
    localparam logic signed [CV_W:0]    Q15_HALF = (CV_W+1)'(16384);
    localparam logic signed [18:0]      Q15_MAX = 19'sd32767;
    localparam logic signed [18:0]      Q15_MIN = -19'sd32768;

    // Architectural state.
    logic signed [POS_W-1:0] r_pos_x, r_pos_y;
    logic [ANG_W-1:0]        r_heading;
    logic signed [VEL_W-1:0] r_lin, r_ang;

    // Working registers.
    logic [DT_W-1:0]         r_dt;
    logic signed [CV_W-1:0]  r_cos, r_sin;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [POS_W-1:0] r_dist;
    logic [47:0]             r_p;
    logic [63:0]             r_acc;

    // Result register.
    logic signed [POS_W-1:0] r_out_x, r_out_y;
    logic [ANG_W-1:0]        r_out_head;
    logic signed [Q15_W-1:0] r_out_z, r_out_w;
    logic signed [VEL_W-1:0] r_out_lin, r_out_ang;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [CV_W-1:0]  cordic_cos, cordic_sin;
    logic [ANG_W-1:0]        cordic_angle;
    logic [47:0]             dist_sum;
    logic [PROD_W-1:0]       step_sum;
    logic signed [SUM_W-1:0] pos_new;
    logic signed [POS_W-1:0] pos_sat;
    logic [63:0]             head_sum;

    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CV_W-1:0] v);
        logic signed [CV_W:0] t;
        logic signed [18:0]   r;
        t = {v[CV_W-1], v} + Q15_HALF;
        r = t[CV_W:15];
        if (r > Q15_MAX) begin
            r = Q15_MAX;
        end else if (r < Q15_MIN) begin
            r = Q15_MIN;
        end
        return r[Q15_W-1:0];
    endfunction

    // Sine and cosine unit: the old heading for the move, half the new one for the quaternion.
    assign cordic_angle = i_cmd.cordic_init_half ? {1'b0, r_heading[ANG_W-1:1]} : r_heading;

    drpi_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (i_cmd.load_tick | i_cmd.cordic_init_half),
        .i_angle (cordic_angle),
        .i_step  (i_cmd.cordic_step),
        .o_last  (o_status.cordic_last),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SPEED_DT: begin
                mul_a = {{(MUL_W-VEL_W){r_lin[VEL_W-1]}}, r_lin};
                mul_b = {{(MUL_W-DT_W){1'b0}}, r_dt};
            end
            MUL_RATE_DT: begin
                mul_a = {{(MUL_W-VEL_W){r_ang[VEL_W-1]}}, r_ang};
                mul_b = {{(MUL_W-DT_W){1'b0}}, r_dt};
            end
            MUL_DIST_COS: begin
                mul_a = {{(MUL_W-POS_W){r_dist[POS_W-1]}}, r_dist};
                mul_b = r_cos;
            end
            MUL_DIST_SIN: begin
                mul_a = {{(MUL_W-POS_W){r_dist[POS_W-1]}}, r_dist};
                mul_b = r_sin;
            end
            MUL_PLO_K: begin
                mul_a = {{(MUL_W-24){1'b0}}, r_p[23:0]};
                mul_b = {{(MUL_W-K_W){1'b0}}, INV_TWO_PI_Q32};
            end
            MUL_PHI_K: begin
                mul_a = {{(MUL_W-24){r_p[47]}}, r_p[47:24]};
                mul_b = {{(MUL_W-K_W){1'b0}}, INV_TWO_PI_Q32};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Rounding of the product into distance, position step and heading step.
    always_comb begin
        dist_sum = r_prod[47:0] + 48'd32768;
        step_sum = r_prod + PROD_W'(64'h20000000);
        pos_new  = (i_cmd.act == ACT_X ? SUM_W'(r_pos_x) : SUM_W'(r_pos_y))
                 + SUM_W'($signed(step_sum[PROD_W-1:30]));
        if (pos_new > POS_MAX) begin
            pos_sat = POS_MAX[POS_W-1:0];
        end else if (pos_new < POS_MIN) begin
            pos_sat = POS_MIN[POS_W-1:0];
        end else begin
            pos_sat = pos_new[POS_W-1:0];
        end
        head_sum = r_acc + {r_prod[39:0], 24'b0};
    end

    // Pose and stored velocities.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
            r_lin     <= '0;
            r_ang     <= '0;
        end else begin
            if (i_cmd.load_vel) begin
                r_lin <= i_linear_velocity;
                r_ang <= i_angular_velocity;
            end
            if (i_cmd.act == ACT_X) begin
                r_pos_x <= pos_sat;
            end
            if (i_cmd.act == ACT_Y) begin
                r_pos_y <= pos_sat;
            end
            if (i_cmd.act == ACT_HEAD) begin
                r_heading <= r_heading + head_sum[63:32];
            end
        end
    end

    // Working registers of a tick.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tick) begin
            r_dt <= i_elapsed_time;
        end
        if (i_cmd.cap_cs) begin
            r_cos <= cordic_cos;
            r_sin <= cordic_sin;
        end
        if (i_cmd.act == ACT_DIST) begin
            r_dist <= dist_sum[47:16];
        end
        if (i_cmd.act == ACT_P) begin
            r_p <= r_prod[47:0];
        end
        if (i_cmd.act == ACT_ACC) begin
            r_acc <= r_prod[63:0] + 64'h80000000;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.act == ACT_OUT) begin
            r_out_x    <= r_pos_x;
            r_out_y    <= r_pos_y;
            r_out_head <= r_heading;
            r_out_z    <= to_q15(r_sin);
            r_out_w    <= to_q15(r_cos);
            r_out_lin  <= r_lin;
            r_out_ang  <= r_ang;
        end
    end

    assign o_pos_x          = r_out_x;
    assign o_pos_y          = r_out_y;
    assign o_heading_angle  = r_out_head;
    assign o_quat_z         = r_out_z;
    assign o_quat_w         = r_out_w;
    assign o_speed_echo     = r_out_lin;
    assign o_turn_rate_echo = r_out_ang;

endmodule

/* rtl/drpi_ctrl.sv */
module drpi_ctrl
    import drpi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_kind,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   s_accept;
    logic   out_free;

    assign s_accept = i_s_tvalid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_m_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && i_s_kind == KIND_TICK) begin
                    n_state = ST_CORD_A;
                end
            end
            ST_CORD_A: begin
                if (i_status.cordic_last) begin
                    n_state = ST_MUL_D;
                end
            end
            ST_MUL_D:  n_state = ST_DIST;
            ST_DIST:   n_state = ST_MUL_X;
            ST_MUL_X:  n_state = ST_MUL_Y;
            ST_MUL_Y:  n_state = ST_MUL_PL;
            ST_MUL_PL: n_state = ST_MUL_PH;
            ST_MUL_PH: n_state = ST_HEAD;
            ST_HEAD:   n_state = ST_INIT_B;
            ST_INIT_B: n_state = ST_CORD_B;
            ST_CORD_B: begin
                if (i_status.cordic_last) begin
                    n_state = ST_CAP_B;
                end
            end
            ST_CAP_B:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd            = '0;
        o_cmd.mul_sel    = MUL_SPEED_DT;
        o_cmd.act        = ACT_NONE;
        o_s_tready       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready      = 1'b1;
                o_cmd.load_vel  = s_accept && (i_s_kind == KIND_CMD);
                o_cmd.load_tick = s_accept && (i_s_kind == KIND_TICK);
            end
            ST_CORD_A: o_cmd.cordic_step = 1'b1;
            ST_MUL_D: begin
                o_cmd.cap_cs  = 1'b1;
                o_cmd.mul_sel = MUL_SPEED_DT;
            end
            ST_DIST: begin
                o_cmd.act     = ACT_DIST;
                o_cmd.mul_sel = MUL_RATE_DT;
            end
            ST_MUL_X: begin
                o_cmd.act     = ACT_P;
                o_cmd.mul_sel = MUL_DIST_COS;
            end
            ST_MUL_Y: begin
                o_cmd.act     = ACT_X;
                o_cmd.mul_sel = MUL_DIST_SIN;
            end
            ST_MUL_PL: begin
                o_cmd.act     = ACT_Y;
                o_cmd.mul_sel = MUL_PLO_K;
            end
            ST_MUL_PH: begin
                o_cmd.act     = ACT_ACC;
                o_cmd.mul_sel = MUL_PHI_K;
            end
            ST_HEAD:   o_cmd.act = ACT_HEAD;
            ST_INIT_B: o_cmd.cordic_init_half = 1'b1;
            ST_CORD_B: o_cmd.cordic_step = 1'b1;
            ST_CAP_B:  o_cmd.cap_cs = 1'b1;
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.act = ACT_OUT;
                end
            end
            default: o_s_tready = 1'b0;
        endcase
    end

    // Result valid flag: set when the result register loads, cleared when taken.
    always_comb begin
        n_out_valid = (r_out_valid && !i_m_tready) || (o_cmd.act == ACT_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

/* rtl/drpi_checker.sv */
module drpi_checker
    import drpi_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [175:0] o_m_axis_tdata
);

    logic s_accept;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // No result is pending right after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // A tick occupies the block: no item is taken in the next cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_axis_tuser == KIND_TICK |=> !o_s_axis_tready)
        else $error("item taken while a tick is in work");

    // A velocity command creates no result.
    a_cmd_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && i_s_axis_tuser == KIND_CMD && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("command produced a result");

    // A result appears only at the end of a tick, while input is held off.
    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared outside a tick");

endmodule

bind dead_reckoning_pose_integrator_top drpi_checker u_drpi_checker (.*);
